// ----- sv/gryo_pkg.sv -----
package gryo_pkg;

    localparam int WIDE_COLUMNS   = 14;
    localparam int NARROW_COLUMNS = 8;
    localparam int NUM_DRAWS      = 8;
    localparam int DRAW_W         = $clog2(NUM_DRAWS);

    // configuration register indexes
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_LINE_STRIDE   = 3'd2;
    localparam logic [2:0] REG_ROTATE_ENABLE = 3'd3;
    localparam logic [2:0] REG_ROTATE_BASE   = 3'd4;
    localparam logic [2:0] REG_FG_COLOR      = 3'd5;
    localparam logic [2:0] REG_BG_COLOR      = 3'd6;

    // write forms
    localparam logic [1:0] FORM_UNIT = 2'd0;
    localparam logic [1:0] FORM_EVEN = 2'd1;
    localparam logic [1:0] FORM_ODD  = 2'd2;

    typedef struct packed {
        logic signed [11:0] x_pos;
        logic signed [11:0] y_pos;
        logic [7:0]         row_bits;
        logic               upscaled;
    } t_in;

    typedef struct packed {
        logic [22:0] unit_index;
        logic [1:0]  write_form;
        logic [31:0] yuv_word;
        logic [15:0] opacity_pair;
        logic        last_write;
    } t_out;

    typedef struct packed {
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
        logic [7:0] o;
    } t_col;

    // palette byte to Y, U, V and opacity
    function automatic t_col decode_col(input logic [7:0] c);
        t_col       r;
        logic [7:0] t;
        t   = c + 8'd1;
        r.y = (8'd0 - c) & 8'hF0;
        r.o = (c[3:0] != 4'd0) ? 8'hFF : c;
        if (!t[1]) begin
            r.u = 8'd128;
            r.v = 8'd128;
        end else begin
            r.u = 8'((t * 3) & 8'hFF);
            r.v = {c[4:0], 3'b000};
        end
        return r;
    endfunction

    // widen an 8 pixel row to 14 pixels
    function automatic logic [13:0] widen_row(input logic [7:0] b);
        return {b[7], b[6], b[6], b[5], b[5], b[4], b[4], b[3], b[3],
                b[2], b[2], b[1], b[0], b[0]};
    endfunction

endpackage

// ----- sv/glyph_row_yuv_overlay_writer.sv -----
// Draws one glyph row per start into a YUV422 overlay. Each accepted row gives
// up to sixteen writes, one per clock cycle on o_res with o_res_valid high for
// that cycle only; o_res.last_write marks the final write of a row, and a row
// that is fully clipped gives none. The row runs through three stages (palette
// decode and line product, per-draw clip and offset, rotation and guard) and
// then a write sequencer that issues one write per cycle; a row holds the sequencer
// until its last write is out. busy is high while the stages are full behind
// the sequencer. The receiver cannot stall: results must be taken as they come.
// Configuration is written on the cfg channel, which is always ready.
module glyph_row_yuv_overlay_writer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  gryo_pkg::t_in     i_item,
    output logic              o_res_valid,
    output gryo_pkg::t_out    o_res,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [23:0]       i_cfg_data
);
    import gryo_pkg::*;

    // configuration
    logic [11:0] r_width, r_height;
    logic [12:0] r_stride;
    logic        r_rot;
    logic [23:0] r_rbase;
    logic [7:0]  r_fg, r_bg;

    logic [12:0] stride_e;
    logic [11:0] half;
    assign stride_e = {r_stride[12:1], 1'b0};
    assign half     = r_stride[12:1];

    // handshake chain
    logic rdy1, rdy2, rdy3, rdy_e, e_done, take3, accept;
    logic r_v1, r_v2, r_v3;

    // stage 1
    t_in         r1_in;
    logic [13:0] r1_row;
    logic [23:0] r1_prod;
    t_col        r1_fg, r1_bg;

    // stage 2
    logic              r2_rep;
    logic [NUM_DRAWS-1:0] r2_use, r2_pair;
    logic [23:0]       r2_off [NUM_DRAWS];
    logic [1:0]        r2_px  [NUM_DRAWS];
    t_col              r2_fg, r2_bg;
    logic [NUM_DRAWS-1:0] n2_use, n2_pair;
    logic [23:0]       n2_off [NUM_DRAWS];
    logic [1:0]        n2_px  [NUM_DRAWS];
    logic signed [12:0] col   [NUM_DRAWS];
    logic [3:0]        sh     [NUM_DRAWS];
    logic [13:0]       pb     [NUM_DRAWS];
    logic [12:0]       y_end;
    logic              y_ok;

    // stage 3
    logic                 r3_rep;
    logic [NUM_DRAWS-1:0] r3_use;
    logic [22:0]          r3_unit [NUM_DRAWS];
    logic [1:0]           r3_form [NUM_DRAWS];
    logic [31:0]          r3_yuv  [NUM_DRAWS];
    logic [15:0]          r3_op   [NUM_DRAWS];
    logic [NUM_DRAWS-1:0] n3_use;
    logic [22:0]          n3_unit [NUM_DRAWS];
    logic [1:0]           n3_form [NUM_DRAWS];
    logic [31:0]          n3_yuv  [NUM_DRAWS];
    logic [15:0]          n3_op   [NUM_DRAWS];
    logic [23:0]          offr    [NUM_DRAWS];
    t_col                 ca      [NUM_DRAWS];
    t_col                 cb      [NUM_DRAWS];

    // sequencer
    logic                 r_act, r_line, r_erep;
    logic [NUM_DRAWS-1:0] r_pend;
    logic [22:0]          r_eunit [NUM_DRAWS];
    logic [1:0]           r_eform [NUM_DRAWS];
    logic [31:0]          r_eyuv  [NUM_DRAWS];
    logic [15:0]          r_eop   [NUM_DRAWS];
    logic [DRAW_W-1:0]    cur;
    logic                 one_left;
    logic [22:0]          cur_unit;

    t_out r_o;
    logic r_o_valid;

    // ready chain from the sequencer back to the input
    assign rdy_e  = !r_act || e_done;
    assign take3  = r_v3 && rdy_e && (r3_use != '0);
    assign rdy3   = !r_v3 || rdy_e || (r3_use == '0);
    assign rdy2   = !r_v2 || rdy3;
    assign rdy1   = !r_v1 || rdy2;
    assign busy   = !rdy1;
    assign accept = start && !busy;
    assign o_cfg_ready = 1'b1;

    // hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 12'd640;
            r_height <= 12'd480;
            r_stride <= 13'd640;
            r_rot    <= 1'b0;
            r_rbase  <= 24'd0;
            r_fg     <= 8'd255;
            r_bg     <= 8'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SCREEN_WIDTH:  r_width  <= i_cfg_data[11:0];
                REG_SCREEN_HEIGHT: r_height <= i_cfg_data[11:0];
                REG_LINE_STRIDE:   r_stride <= i_cfg_data[12:0];
                REG_ROTATE_ENABLE: r_rot    <= i_cfg_data[0];
                REG_ROTATE_BASE:   r_rbase  <= i_cfg_data;
                REG_FG_COLOR:      r_fg     <= i_cfg_data[7:0];
                REG_BG_COLOR:      r_bg     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // stage 1: decode palette, widen row, form line product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= accept;
        end
        if (rdy1) begin
            r1_in   <= i_item;
            r1_row  <= i_item.upscaled ? widen_row(i_item.row_bits)
                                       : {6'd0, i_item.row_bits};
            r1_prod <= 24'({13'd0, i_item.y_pos[10:0]} * {11'd0, stride_e});
            r1_fg   <= decode_col(r_fg);
            r1_bg   <= decode_col(r_bg);
        end
    end

    // stage 2: lay out draws, clip, add column
    assign y_end = 13'({1'b0, r1_in.y_pos[11:0]} + {12'd0, r1_in.upscaled});
    assign y_ok  = !r1_in.y_pos[11] && (y_end < {1'b0, r_height});

    always_comb begin
        for (int j = 0; j < NUM_DRAWS; j++) begin
            col[j]     = '0;
            sh[j]      = '0;
            n2_pair[j] = 1'b1;
            n2_use[j]  = 1'b0;
            if (!r1_in.x_pos[0]) begin
                col[j]    = 13'($signed(r1_in.x_pos) + 13'(2 * j));
                sh[j]     = r1_in.upscaled ? 4'(WIDE_COLUMNS - 2 - 2 * j)
                                           : 4'(NARROW_COLUMNS - 2 - 2 * j);
                n2_use[j] = r1_in.upscaled ? (j < WIDE_COLUMNS / 2)
                                           : (j < NARROW_COLUMNS / 2);
            end else if (j == 0) begin
                col[j]     = 13'($signed(r1_in.x_pos));
                sh[j]      = r1_in.upscaled ? 4'(WIDE_COLUMNS - 1) : 4'(NARROW_COLUMNS - 1);
                n2_pair[j] = 1'b0;
                n2_use[j]  = 1'b1;
            end else begin
                col[j] = 13'($signed(r1_in.x_pos) + 13'(2 * j - 1));
                if ((r1_in.upscaled && j < WIDE_COLUMNS / 2)
                        || (!r1_in.upscaled && j < NARROW_COLUMNS / 2)) begin
                    sh[j]     = r1_in.upscaled ? 4'(WIDE_COLUMNS - 1 - 2 * j)
                                               : 4'(NARROW_COLUMNS - 1 - 2 * j);
                    n2_use[j] = 1'b1;
                end else if ((r1_in.upscaled && j == WIDE_COLUMNS / 2)
                        || (!r1_in.upscaled && j == NARROW_COLUMNS / 2)) begin
                    sh[j]      = 4'd0;
                    n2_pair[j] = 1'b0;
                    n2_use[j]  = 1'b1;
                end
            end
            pb[j]    = r1_row >> sh[j];
            n2_px[j] = pb[j][1:0];
            // drop draws that fall off the screen
            if (col[j][12] || !y_ok || (col[j][11:0] >= r_width)) n2_use[j] = 1'b0;
            if (n2_pair[j] && ({1'b0, col[j][11:0]} + 13'd1 >= {1'b0, r_width}))
                n2_use[j] = 1'b0;
            n2_off[j] = r1_prod + {12'd0, col[j][11:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
        if (rdy2) begin
            r2_rep  <= r1_in.upscaled;
            r2_use  <= n2_use;
            r2_pair <= n2_pair;
            r2_off  <= n2_off;
            r2_px   <= n2_px;
            r2_fg   <= r1_fg;
            r2_bg   <= r1_bg;
        end
    end

    // stage 3: rotate, guard, build words
    always_comb begin
        for (int j = 0; j < NUM_DRAWS; j++) begin
            offr[j]    = r_rot ? (r_rbase - r2_off[j]) : r2_off[j];
            n3_use[j]  = r2_use[j];
            ca[j]      = r2_bg;
            cb[j]      = r2_bg;
            n3_unit[j] = offr[j][23:1];
            n3_form[j] = FORM_UNIT;
            n3_yuv[j]  = '0;
            n3_op[j]   = '0;
            if (r2_pair[j]) begin
                n3_unit[j] = r_rot ? (r_rbase[23:1] - r2_off[j][23:1]) : r2_off[j][23:1];
                ca[j] = (r_rot ? r2_px[j][0] : r2_px[j][1]) ? r2_fg : r2_bg;
                cb[j] = (r_rot ? r2_px[j][1] : r2_px[j][0]) ? r2_fg : r2_bg;
                if (n3_unit[j] == '0) n3_use[j] = 1'b0;
                n3_yuv[j] = {cb[j].y, ca[j].v, ca[j].y, ca[j].u};
                n3_op[j]  = {ca[j].o, ca[j].o};
            end else begin
                ca[j] = r2_px[j][0] ? r2_fg : r2_bg;
                if (offr[j] == '0) n3_use[j] = 1'b0;
                if (offr[j][0]) begin
                    n3_form[j] = FORM_ODD;
                    n3_yuv[j]  = {ca[j].y, 24'd0};
                    n3_op[j]   = {ca[j].o, 8'd0};
                end else begin
                    n3_form[j] = FORM_EVEN;
                    n3_yuv[j]  = {8'd0, ca[j].v, ca[j].y, ca[j].u};
                    n3_op[j]   = {8'd0, ca[j].o};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
        if (rdy3) begin
            r3_rep  <= r2_rep;
            r3_use  <= n3_use;
            r3_unit <= n3_unit;
            r3_form <= n3_form;
            r3_yuv  <= n3_yuv;
            r3_op   <= n3_op;
        end
    end

    // pick the lowest pending draw
    always_comb begin
        cur = '0;
        for (int j = NUM_DRAWS - 1; j >= 0; j--) begin
            if (r_pend[j]) cur = DRAW_W'(j);
        end
    end

    assign one_left = (r_pend & (r_pend - NUM_DRAWS'(1))) == '0;
    assign e_done   = r_act && one_left && (r_line == r_erep);
    assign cur_unit = !r_line ? r_eunit[cur]
                    : (r_rot ? (r_eunit[cur] - {11'd0, half})
                             : (r_eunit[cur] + {11'd0, half}));

    // sequence the writes, one per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act     <= 1'b0;
            r_pend    <= '0;
            r_line    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_act;
            if (rdy_e) begin
                r_act  <= take3;
                r_pend <= r3_use;
                r_line <= 1'b0;
            end else if (r_erep && !r_line) begin
                r_line <= 1'b1;
            end else begin
                r_line       <= 1'b0;
                r_pend[cur]  <= 1'b0;
            end
        end
        if (take3) begin
            r_erep  <= r3_rep;
            r_eunit <= r3_unit;
            r_eform <= r3_form;
            r_eyuv  <= r3_yuv;
            r_eop   <= r3_op;
        end
        r_o.unit_index   <= cur_unit;
        r_o.write_form   <= r_eform[cur];
        r_o.yuv_word     <= r_eyuv[cur];
        r_o.opacity_pair <= r_eop[cur];
        r_o.last_write   <= e_done;
    end

    assign o_res_valid = r_o_valid;
    assign o_res       = r_o;

endmodule

// ----- sv/gryo_checker.sv -----
module gryo_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_res_valid,
    input gryo_pkg::t_out o_res
);
    import gryo_pkg::*;

    // no word straight after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_res_valid)
        else $error("word after reset");

    // a row's words come without gaps up to its last
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.last_write |=> o_res_valid)
        else $error("gap inside a row");

    // only defined forms
    a_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.write_form == FORM_UNIT || o_res.write_form == FORM_EVEN
                         || o_res.write_form == FORM_ODD))
        else $error("bad write form");

    // odd pixel writes touch byte 3 only
    a_odd_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.write_form == FORM_ODD
            |-> o_res.yuv_word[23:0] == 24'd0 && o_res.opacity_pair[7:0] == 8'd0)
        else $error("odd pixel write touches even bytes");

endmodule

bind glyph_row_yuv_overlay_writer gryo_checker u_gryo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);

// ----- sim/glyph_row_yuv_overlay_writer_tb.sv -----
`timescale 1ns / 100ps

module glyph_row_yuv_overlay_writer_tb;
    import gryo_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in         i_item;
    logic        o_res_valid;
    t_out        o_res;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [23:0] i_cfg_data;

    // shadow copy of the configuration registers
    logic [11:0] scr_w;
    logic [11:0] scr_h;
    logic [12:0] stride_reg;
    logic        rot_en;
    logic [23:0] rot_base;
    logic [7:0]  fg_reg;
    logic [7:0]  bg_reg;

    t_out expected_writes[$];
    int   mismatch_cnt;
    int   write_cnt;
    int   row_cnt;
    int   sender_idle_pct;

    // palette decode, kept separate from the block's own
    logic [7:0] pal_y[2];
    logic [7:0] pal_u[2];
    logic [7:0] pal_v[2];
    logic [7:0] pal_o[2];

    glyph_row_yuv_overlay_writer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // work out Y, U, V and opacity of one palette byte
    task automatic load_palette(input int k, input logic [7:0] c);
        logic [7:0] t;
        t = c + 8'd1;
        pal_y[k] = (8'd0 - c) & 8'hF0;
        pal_o[k] = (c[3:0] != 0) ? 8'hFF : c;
        if (!t[1]) begin
            pal_u[k] = 8'd128;
            pal_v[k] = 8'd128;
        end else begin
            pal_u[k] = t * 8'd3;
            pal_v[k] = c << 3;
        end
    endtask

    task automatic push_write(input logic [22:0] unit, input logic [1:0] form,
                              input logic [31:0] yuv, input logic [15:0] op);
        t_out w;
        w.unit_index   = unit;
        w.write_form   = form;
        w.yuv_word     = yuv;
        w.opacity_pair = op;
        w.last_write   = 1'b0;
        expected_writes.push_back(w);
    endtask

    task automatic predict_single(input int x, input int y, input int b, input int rep);
        logic [23:0] stride;
        logic [23:0] off;
        stride = {11'd0, stride_reg & 13'h1FFE};
        if (x < 0 || y < 0 || x >= int'(scr_w) || y + rep >= int'(scr_h)) return;
        off = 24'(y) * stride + 24'(x);
        if (rot_en) off = rot_base - off;
        if (off == 0) return;
        for (int k = 0; k <= rep; k++) begin
            if (off[0])
                push_write(off[23:1], FORM_ODD, {pal_y[b], 24'd0}, {pal_o[b], 8'd0});
            else
                push_write(off[23:1], FORM_EVEN, {8'd0, pal_v[b], pal_y[b], pal_u[b]},
                           {8'd0, pal_o[b]});
            off = rot_en ? off - stride : off + stride;
        end
    endtask

    task automatic predict_pair(input int x, input int y, input logic [1:0] px,
                                input int rep);
        logic [23:0] stride;
        logic [23:0] off;
        logic [22:0] unit;
        int          a;
        int          b;
        stride = {11'd0, stride_reg & 13'h1FFE};
        if (x < 0 || y < 0 || x + 1 >= int'(scr_w) || y + rep >= int'(scr_h)) return;
        off  = 24'(y) * stride + 24'(x);
        unit = off[23:1];
        if (rot_en) begin
            unit = rot_base[23:1] - unit;
            a = px[0];
            b = px[1];
        end else begin
            a = px[1];
            b = px[0];
        end
        if (unit == 0) return;
        for (int k = 0; k <= rep; k++) begin
            push_write(unit, FORM_UNIT, {pal_y[b], pal_v[a], pal_y[a], pal_u[a]},
                       {pal_o[a], pal_o[a]});
            unit = rot_en ? unit - stride[23:1] : unit + stride[23:1];
        end
    endtask

    // expected writes of one glyph row
    task automatic predict_row(input t_in it);
        int          x;
        int          y;
        int          cols;
        int          rep;
        int          first;
        logic [13:0] row;
        x     = int'(it.x_pos);
        y     = int'(it.y_pos);
        cols  = it.upscaled ? 14 : 8;
        rep   = it.upscaled ? 1 : 0;
        first = expected_writes.size();
        load_palette(0, bg_reg);
        load_palette(1, fg_reg);
        row = {6'd0, it.row_bits};
        if (it.upscaled) begin
            row = '0;
            for (int j = 0; j < 8; j++) begin
                if (it.row_bits[j]) begin
                    case (j)
                        0: row |= 14'h3;
                        1: row |= 14'h4;
                        7: row |= 14'h2000;
                        default: row |= 14'h3 << (2 * j - 1);
                    endcase
                end
            end
        end
        if (x % 2 != 0) begin
            predict_single(x, y, row[cols-1], rep);
            for (int i = 1; i + 1 < cols - 1; i += 2)
                predict_pair(x + i, y, 2'((row >> (cols - 2 - i)) & 14'd3), rep);
            predict_single(x + cols - 1, y, row[0], rep);
        end else begin
            for (int i = 0; i + 1 < cols; i += 2)
                predict_pair(x + i, y, 2'((row >> (cols - 2 - i)) & 14'd3), rep);
        end
        if (expected_writes.size() > first)
            expected_writes[expected_writes.size()-1].last_write = 1'b1;
    endtask

    // compare every write against the oldest expectation
    always @(posedge i_clk) begin
        t_out exp_w;
        if (i_rst_n && o_res_valid) begin
            write_cnt++;
            if (expected_writes.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected write %h", o_res);
            end else begin
                exp_w = expected_writes.pop_front();
                if (o_res.unit_index !== exp_w.unit_index ||
                    o_res.write_form !== exp_w.write_form ||
                    o_res.yuv_word !== exp_w.yuv_word ||
                    o_res.opacity_pair !== exp_w.opacity_pair ||
                    o_res.last_write !== exp_w.last_write) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("write mismatch: expected %h actual %h", exp_w, o_res);
                end
            end
        end
    end

    // send one glyph row, with a random idle gap first
    task automatic send_row(input t_in it);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_row(it);
        row_cnt++;
    endtask

    task automatic send_fields(input int x, input int y, input int bits, input bit up);
        t_in it;
        it.x_pos    = 12'(x);
        it.y_pos    = 12'(y);
        it.row_bits = 8'(bits);
        it.upscaled = up;
        send_row(it);
    endtask

    task automatic drain_writes();
        start <= 1'b0;
        while (expected_writes.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_SCREEN_WIDTH:  scr_w      = val[11:0];
            REG_SCREEN_HEIGHT: scr_h      = val[11:0];
            REG_LINE_STRIDE:   stride_reg = val[12:0];
            REG_ROTATE_ENABLE: rot_en     = val[0];
            REG_ROTATE_BASE:   rot_base   = val;
            REG_FG_COLOR:      fg_reg     = val[7:0];
            REG_BG_COLOR:      bg_reg     = val[7:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_screen(input int w, input int h, input int s, input bit rot,
                              input int base, input int fg, input int bg);
        drain_writes();
        write_reg(REG_SCREEN_WIDTH, 24'(w));
        write_reg(REG_SCREEN_HEIGHT, 24'(h));
        write_reg(REG_LINE_STRIDE, 24'(s));
        write_reg(REG_ROTATE_ENABLE, 24'(rot));
        write_reg(REG_ROTATE_BASE, 24'(base));
        write_reg(REG_FG_COLOR, 24'(fg));
        write_reg(REG_BG_COLOR, 24'(bg));
    endtask

    // field extremes, both widths, odd and even x, clipping and the guard unit
    task automatic test_directed();
        send_fields(10, 10, 8'hA5, 1'b0);
        send_fields(11, 10, 8'hA5, 1'b0);
        send_fields(10, 10, 8'h5A, 1'b1);
        send_fields(11, 12, 8'hFF, 1'b1);
        send_fields(0, 0, 8'h00, 1'b0);
        send_fields(1, 0, 8'h81, 1'b1);
        send_fields(-2048, -2048, 8'hFF, 1'b1);
        send_fields(2047, 2047, 8'hFF, 1'b0);
        send_fields(-3, 5, 8'hC3, 1'b0);
        send_fields(635, 478, 8'hF0, 1'b1);
        send_fields(633, 479, 8'h0F, 1'b0);
        send_fields(637, 100, 8'h3C, 1'b1);
        set_screen(4095, 4095, 4096, 1'b1, 24'hFFFFFF, 8'h12, 8'hED);
        send_fields(2047, 2047, 8'hAA, 1'b1);
        send_fields(0, 0, 8'h55, 1'b0);
        send_fields(1, 1, 8'h99, 1'b1);
        set_screen(1, 1, 3, 1'b1, 20, 8'h02, 8'hF1);
        send_fields(0, 0, 8'hFF, 1'b0);
        send_fields(-1, 0, 8'hFF, 1'b1);
        set_screen(16, 4, 2, 1'b1, 8, 8'h7E, 8'h81);
        send_fields(0, 0, 8'hA5, 1'b0);
        send_fields(1, 1, 8'h5A, 1'b1);
        send_fields(3, 2, 8'hFF, 1'b0);
    endtask

    // random rows, mostly around the visible window
    task automatic test_random(input int n);
        int x;
        int y;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 8) begin
                x = $urandom_range(int'(scr_w) + 20) - 16;
                y = $urandom_range(int'(scr_h) + 4) - 3;
            end else begin
                x = $urandom_range(4095) - 2048;
                y = $urandom_range(4095) - 2048;
            end
            send_fields(x, y, $urandom_range(255), 1'($urandom_range(1)));
        end
    endtask

    task automatic random_screen();
        set_screen($urandom_range(4095, 1), $urandom_range(4095, 1), $urandom_range(4096, 2),
                   1'($urandom_range(1)), $urandom_range(24'hFFFFFF), $urandom_range(255),
                   $urandom_range(255));
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_item          = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = REG_SCREEN_WIDTH;
        i_cfg_data      = '0;
        scr_w           = 12'd640;
        scr_h           = 12'd480;
        stride_reg      = 13'd640;
        rot_en          = 1'b0;
        rot_base        = 24'd0;
        fg_reg          = 8'd255;
        bg_reg          = 8'd0;
        mismatch_cnt    = 0;
        write_cnt       = 0;
        row_cnt         = 0;
        sender_idle_pct = 15;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        for (int p = 0; p < 3; p++) begin
            sender_idle_pct = (p == 0) ? 15 : (p == 1) ? 59 : 0;
            set_screen(640, 480, 640, p[0], 24'h3FFFF, $urandom_range(255),
                       $urandom_range(255));
            test_random(40);
            random_screen();
            test_random(25);
            set_screen($urandom_range(64, 1), $urandom_range(16, 1), $urandom_range(80, 2),
                       1'($urandom_range(1)), $urandom_range(600), $urandom_range(255),
                       $urandom_range(255));
            test_random(15);
        end
        drain_writes();

        $display("Sent %0d glyph rows and checked %0d overlay writes over several screen",
                 row_cnt, write_cnt);
        $display("and palette settings, rotated and unrotated, with %0d mismatches.",
                 mismatch_cnt);
        if (mismatch_cnt == 0 && expected_writes.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // guard against a hung handshake
    initial begin
        #3000000;
        $display("timeout waiting for the block");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
